// ===== sv/bounded_random_from_bits_unit_assert.svh =====
// assertion macros for the bounded random unit
// used by the top level only, no other dependencies
`ifndef BOUNDED_RANDOM_FROM_BITS_UNIT_ASSERT_SVH
`define BOUNDED_RANDOM_FROM_BITS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clk outside reset
`define BRFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BRFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRFB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BRFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/brfb_pkg.sv =====
// shared types, constants and helper functions for the bounded random unit
// no dependencies
package brfb_pkg;

    localparam int VALUE_BITS = 31;

    typedef logic [VALUE_BITS-1:0] word_t;

    // payload carried from cell to cell
    typedef struct packed {
        word_t lo;
        word_t hi;
        word_t src;
        word_t v;
        logic  done;
        logic  err;
    } stage_t;

    function automatic logic in_range(word_t v, word_t lo, word_t hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // smear the leading one down to bit 0
    function automatic word_t fill_below(word_t x);
        word_t r;
        r = x;
        for (int s = 1; s < VALUE_BITS; s = s * 2)
        begin
            r = r | (r >> s);
        end
        return r;
    endfunction

endpackage

// ===== sv/brfb_if.sv =====
// handshake channels of the bounded random unit: request and result
// depends on brfb_pkg
interface brfb_req_if
    import brfb_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t low_bound;
    word_t high_bound;
    word_t random_bits;
    logic  toward_high;

    modport source (output valid, low_bound, high_bound, random_bits, toward_high,
                    input ready);
    modport sink   (input valid, low_bound, high_bound, random_bits, toward_high,
                    output ready);
endinterface

interface brfb_rsp_if
    import brfb_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t value;
    logic  range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink   (input valid, value, range_error, output ready);
endinterface

// ===== sv/brfb_front.sv =====
// entry stage: bound check, field mask and first range test
// depends on brfb_pkg
module brfb_front
    import brfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  word_t  low_bound,
    input  word_t  high_bound,
    input  word_t  random_bits,
    input  logic   toward_high,
    output logic   in_ready,
    output logic   out_valid,
    output stage_t out_data,
    input  logic   out_ready
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   advance;

    // stage may load when empty or when its beat moves on
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // masked random word, inverted bounds force value zero and stop the walk
    always_comb
    begin
        data_next.lo  = low_bound;
        data_next.hi  = high_bound;
        data_next.src = toward_high ? high_bound : low_bound;
        data_next.err = low_bound > high_bound;
        if (data_next.err)
        begin
            data_next.v    = '0;
            data_next.done = 1'b1;
        end
        else
        begin
            data_next.v    = random_bits & fill_below(high_bound);
            data_next.done = in_range(data_next.v, low_bound, high_bound);
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/brfb_cell.sv =====
// one fix-up cell: copies one bit from the source bound unless already in range
// depends on brfb_pkg
module brfb_cell
    import brfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  word_t  bit_sel,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   in_ready,
    output logic   out_valid,
    output stage_t out_data,
    input  logic   out_ready
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   advance;

    // stage may load when empty or when its beat moves on
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // replace this cell's bit and retest the range
    always_comb
    begin
        data_next = in_data;
        if (!in_data.done)
        begin
            data_next.v    = (in_data.v & ~bit_sel) | (in_data.src & bit_sel);
            data_next.done = in_range(data_next.v, in_data.lo, in_data.hi);
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/bounded_random_from_bits_unit.sv =====
// top level of the bounded random unit: entry stage and a row of fix-up cells
// depends on brfb_pkg, brfb_if, brfb_front, brfb_cell and the assertion header
//
// Usage: each request beat on "bounds" carries low_bound, high_bound, a fresh
// random_bits word and toward_high. One result beat per request leaves on
// "result" with value in [low_bound, high_bound], or range_error set and value
// zero when low_bound exceeds high_bound.
// The random word is masked below the leading one of high_bound, then a row of
// VALUE_BITS cells walks from the top bit down, each cell copying its bit from
// the chosen bound until the value lands inside the range.
// Path: a request beat reaches the result port through one entry stage plus one
// register per cell, the last cell holding the result.
// Throughput: one beat per cycle unless the result stalls; every stage is a register stage.
// Stall: a stalled result holds its stage; each earlier stage keeps loading
// while it or a later stage is empty, so bubbles close up and requests are
// still taken while the result waits, until the row is full.
// Reset: asynchronous, clears all stage valid flags; no request is in flight
// afterwards and bounds.ready is high at once.
`include "bounded_random_from_bits_unit_assert.svh"

module bounded_random_from_bits_unit
    import brfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    brfb_req_if.sink   bounds,
    brfb_rsp_if.source result
);

    logic   chain_valid [0:VALUE_BITS];
    logic   chain_ready [0:VALUE_BITS];
    stage_t chain_data  [0:VALUE_BITS];

    // entry stage
    brfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (bounds.valid),
        .low_bound   (bounds.low_bound),
        .high_bound  (bounds.high_bound),
        .random_bits (bounds.random_bits),
        .toward_high (bounds.toward_high),
        .in_ready    (bounds.ready),
        .out_valid   (chain_valid[0]),
        .out_data    (chain_data[0]),
        .out_ready   (chain_ready[0])
    );

    // row of cells, cell k handles bit VALUE_BITS-1-k
    for (genvar k = 0; k < VALUE_BITS; k++)
    begin : g_cell
        brfb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bit_sel   (word_t'(1) << (VALUE_BITS - 1 - k)),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .in_ready  (chain_ready[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    // result channel
    assign chain_ready[VALUE_BITS] = result.ready;
    assign result.valid            = chain_valid[VALUE_BITS];
    assign result.value            = chain_data[VALUE_BITS].v;
    assign result.range_error      = chain_data[VALUE_BITS].err;

    // checks
    `BRFB_ASSERT_SAME(a_walk_done, clk, rst_n, chain_valid[VALUE_BITS], chain_data[VALUE_BITS].done)
    `BRFB_ASSERT_SAME(a_err_zero, clk, rst_n, result.valid && result.range_error, result.value == '0)
    `BRFB_ASSERT_SAME(a_in_bounds, clk, rst_n, result.valid && !result.range_error, in_range(chain_data[VALUE_BITS].v, chain_data[VALUE_BITS].lo, chain_data[VALUE_BITS].hi))
    `BRFB_ASSERT_NEXT(a_front_hold, clk, rst_n, chain_valid[0] && !chain_ready[0], chain_valid[0] && $stable(chain_data[0]))

endmodule
